FILE: hdl/gtp_pkg.sv
package gtp_pkg;

    localparam int PAGE_W          = 12;
    localparam int OFFS_W          = 24;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 12;
    localparam int MAX_PAGES_DEF   = 4096;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int EVQ_DEPTH       = 4;

    localparam logic [PAGE_W-1:0] PAGE_FIELD_MAX = 12'hFFF;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ADV = 2'd2;

    localparam logic [11:0] RST_LINE_WIDTH  = 12'd448;
    localparam logic [7:0]  RST_PAGE_ROWS   = 8'd20;
    localparam logic [7:0]  RST_DEFAULT_ADV = 8'd24;

    typedef struct packed {
        logic [2:0] byte_length;
        logic       is_newline;
        logic [7:0] advance_px;
        logic       last_char;
    } t_item;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic [OFFS_W-1:0] page_start_offset;
        logic              is_summary;
        logic              limit_reached;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic [11:0] line_width_px;
        logic [7:0]  page_rows;
        logic [7:0]  default_advance_px;
    } t_cfg;

    // one classified character: an optional page start and an optional summary
    typedef struct packed {
        logic              page_valid;
        logic [PAGE_W-1:0] page_number;
        logic [OFFS_W-1:0] page_offset;
        logic              summ_valid;
        logic [PAGE_W-1:0] summ_pages;
        logic              limit;
    } t_event;

endpackage

FILE: hdl/gtp_front.sv
module gtp_front #(
    parameter int MAX_PAGES   = gtp_pkg::MAX_PAGES_DEF,
    parameter int OFFSET_BITS = gtp_pkg::OFFSET_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gtp_pkg::t_cfg   i_cfg,
    input  logic            i_push,
    input  gtp_pkg::t_item  i_item,
    input  logic            i_evq_full,
    output logic            o_ev_push,
    output gtp_pkg::t_event o_ev
);

    localparam int PG_W = $clog2(MAX_PAGES + 1);

    logic [12:0]            r_fill,    n_fill;
    logic [7:0]             r_lines,   n_lines;
    logic [OFFSET_BITS-1:0] r_pos,     n_pos;
    logic [PG_W-1:0]        r_pages,   n_pages;
    logic                   r_at_ls,   n_at_ls;
    logic                   r_pending, n_pending;
    logic                   r_limit,   n_limit;

    logic        accept;
    logic [7:0]  adv;
    logic [12:0] fill_sum;
    logic        starts;
    logic [7:0]  lpp_eff;
    logic        new_page;
    logic        page_ok;
    logic [31:0] pages32;
    logic [31:0] pages_n32;
    logic [63:0] pos64;

    assign accept   = i_push && !i_evq_full;
    assign adv      = (i_item.advance_px == 8'd0) ? i_cfg.default_advance_px
                                                  : i_item.advance_px;
    assign fill_sum = r_fill + 13'(adv);
    assign lpp_eff  = (i_cfg.page_rows == 8'd0) ? 8'd1 : i_cfg.page_rows;
    assign new_page = r_pending || (r_lines >= lpp_eff);
    assign page_ok  = r_pages < PG_W'(MAX_PAGES);
    assign pages32  = 32'(r_pages);
    assign pages_n32 = 32'(n_pages);
    assign pos64    = 64'(r_pos);

    always_comb begin
        n_fill    = r_fill;
        n_at_ls   = r_at_ls;
        n_lines   = r_lines;
        n_pages   = r_pages;
        n_pending = r_pending;
        n_limit   = r_limit;
        starts    = 1'b0;

        if (i_item.is_newline) begin
            if (r_at_ls) begin
                starts = 1'b1;
            end else begin
                n_at_ls = 1'b1;
                n_fill  = '0;
            end
        end else begin
            if (r_at_ls || (fill_sum > 13'(i_cfg.line_width_px))) begin
                starts = 1'b1;
                if (12'(adv) > i_cfg.line_width_px) begin
                    // too wide even for an empty line: sits alone
                    n_fill  = '0;
                    n_at_ls = 1'b1;
                end else begin
                    n_fill  = 13'(adv);
                    n_at_ls = 1'b0;
                end
            end else begin
                n_fill = fill_sum;
            end
        end

        if (starts) begin
            if (new_page) begin
                if (page_ok) begin
                    n_pages = r_pages + PG_W'(1);
                end else begin
                    n_limit = 1'b1;
                end
                n_pending = 1'b0;
                n_lines   = 8'd1;
            end else begin
                n_lines = r_lines + 8'd1;
            end
        end

        n_pos = r_pos + OFFSET_BITS'(i_item.byte_length);

        o_ev.page_valid  = starts && new_page && page_ok;
        o_ev.page_number = (pages32 > 32'(gtp_pkg::PAGE_FIELD_MAX))
                         ? gtp_pkg::PAGE_FIELD_MAX : pages32[gtp_pkg::PAGE_W-1:0];
        o_ev.page_offset = pos64[gtp_pkg::OFFS_W-1:0];
        o_ev.summ_valid  = i_item.last_char;
        o_ev.summ_pages  = (pages_n32 > 32'(gtp_pkg::PAGE_FIELD_MAX))
                         ? gtp_pkg::PAGE_FIELD_MAX : pages_n32[gtp_pkg::PAGE_W-1:0];
        o_ev.limit       = n_limit;
    end

    assign o_ev_push = accept && (o_ev.page_valid || o_ev.summ_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_lines   <= '0;
            r_pos     <= '0;
            r_pages   <= '0;
            r_at_ls   <= 1'b1;
            r_pending <= 1'b1;
            r_limit   <= 1'b0;
        end else if (accept) begin
            if (i_item.last_char) begin
                // end of text: stream state back to its start
                r_fill    <= '0;
                r_lines   <= '0;
                r_pos     <= '0;
                r_pages   <= '0;
                r_at_ls   <= 1'b1;
                r_pending <= 1'b1;
                r_limit   <= 1'b0;
            end else begin
                r_fill    <= n_fill;
                r_lines   <= n_lines;
                r_pos     <= n_pos;
                r_pages   <= n_pages;
                r_at_ls   <= n_at_ls;
                r_pending <= n_pending;
                r_limit   <= n_limit;
            end
        end
    end

    a_pending_no_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_lines == 8'd0))
        else $error("page pending with lines already counted");

    a_pages_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= PG_W'(MAX_PAGES))
        else $error("page count past limit");

endmodule

FILE: hdl/gtp_queue.sv
module gtp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gtp_pkg::t_event i_ev,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output gtp_pkg::t_event o_ev
);

    localparam int DEPTH = gtp_pkg::EVQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gtp_pkg::t_event r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_ev    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("event pushed into full queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("event queue count overflow");

endmodule

FILE: hdl/gtp_back.sv
module gtp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ev_valid,
    input  gtp_pkg::t_event  i_ev,
    output logic             o_ev_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output gtp_pkg::t_result o_result
);

    logic             r_out_valid;
    gtp_pkg::t_result r_out, n_out;
    logic             r_half, n_half;
    logic             load;
    logic             emit_page;

    // page beat first, summary beat after it when both are due
    assign load      = (!r_out_valid || i_pop) && i_ev_valid;
    assign emit_page = i_ev.page_valid && !r_half;

    always_comb begin
        n_half = r_half;
        if (emit_page) begin
            n_out.page_number       = i_ev.page_number;
            n_out.page_start_offset = i_ev.page_offset;
            n_out.is_summary        = 1'b0;
            n_out.limit_reached     = 1'b0;
            n_out.last_result       = !i_ev.summ_valid;
            n_half                  = i_ev.summ_valid;
        end else begin
            n_out.page_number       = i_ev.summ_pages;
            n_out.page_start_offset = '0;
            n_out.is_summary        = 1'b1;
            n_out.limit_reached     = i_ev.limit;
            n_out.last_result       = 1'b1;
            n_half                  = 1'b0;
        end
    end

    assign o_ev_pop = load && !(emit_page && i_ev.summ_valid);
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_half      <= n_half;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_half_has_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_ev_valid && i_ev.page_valid && i_ev.summ_valid))
        else $error("split event lost its head entry");

endmodule

FILE: hdl/greedy_text_paginator.sv
// channel   direction  handshake         beat
// item      in         i_push / o_full   i_item   (gtp_pkg::t_item)
// result    out        o_empty / i_pop   o_result (gtp_pkg::t_result)
// config    in         i_cfg_we          i_cfg_index, i_cfg_wdata
//
// One character is taken per cycle while the event queue has room; wrap and page
// decisions finish in that cycle. Results leave at one beat per cycle while popped,
// so a character raising both a page start and a summary costs two output beats;
// a 4-entry event queue absorbs this. Results pass the queue, then an output flop.
// Synchronous active-low reset; config registers return to 448 / 20 / 24.
// o_full rises only when the event queue is full; output stalls back up through it.
module greedy_text_paginator #(
    parameter int MAX_PAGES   = gtp_pkg::MAX_PAGES_DEF,
    parameter int OFFSET_BITS = gtp_pkg::OFFSET_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  gtp_pkg::t_item                     i_item,
    output logic                               o_empty,
    input  logic                               i_pop,
    output gtp_pkg::t_result                   o_result,
    input  logic                               i_cfg_we,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    gtp_pkg::t_cfg   r_cfg;
    gtp_pkg::t_event front_ev, head_ev;
    logic            ev_push, evq_full, evq_empty, ev_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width_px      <= gtp_pkg::RST_LINE_WIDTH;
            r_cfg.page_rows          <= gtp_pkg::RST_PAGE_ROWS;
            r_cfg.default_advance_px <= gtp_pkg::RST_DEFAULT_ADV;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gtp_pkg::CFG_LINE_WIDTH: begin
                    r_cfg.line_width_px <= i_cfg_wdata;
                end
                gtp_pkg::CFG_PAGE_ROWS: begin
                    r_cfg.page_rows <= i_cfg_wdata[7:0];
                end
                gtp_pkg::CFG_DEFAULT_ADV: begin
                    r_cfg.default_advance_px <= i_cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_full = evq_full;

    gtp_front #(
        .MAX_PAGES   (MAX_PAGES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_evq_full (evq_full),
        .o_ev_push  (ev_push),
        .o_ev       (front_ev)
    );

    gtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_ev    (front_ev),
        .o_full  (evq_full),
        .i_pop   (ev_pop),
        .o_empty (evq_empty),
        .o_ev    (head_ev)
    );

    gtp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (!evq_empty),
        .i_ev       (head_ev),
        .o_ev_pop   (ev_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_result   (o_result)
    );

endmodule

FILE: tb/greedy_text_paginator_tb.sv
module greedy_text_paginator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_ITEMS     = 160;
    localparam int PAGE_W        = gtp_pkg::PAGE_W;
    localparam int OFFS_W        = gtp_pkg::OFFS_W;

    // index 3 has no register behind it
    localparam logic [gtp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // expected results of one character, typed in or left to the predictor
    typedef struct packed {
        logic             typed;
        logic [1:0]       n;
        gtp_pkg::t_result r0;
        gtp_pkg::t_result r1;
    } t_char_plan;

    typedef struct packed {
        gtp_pkg::t_item c;
        t_char_plan     p;
    } t_dir_row;

    localparam gtp_pkg::t_result NO_RES  = '0;
    localparam t_char_plan       PREDICT = '0;
    localparam gtp_pkg::t_result PAGE0   = '{12'd0, 24'd0, 1'b0, 1'b0, 1'b1};
    localparam gtp_pkg::t_result PAGE0_M = '{12'd0, 24'd0, 1'b0, 1'b0, 1'b0};
    localparam gtp_pkg::t_result SUMM1   = '{12'd1, 24'd0, 1'b1, 1'b0, 1'b1};

    // under the reset layout: 448 px wide, 20 lines, 24 px default advance
    localparam t_dir_row DIR_ROWS [16] = '{
        '{'{3'd1, 1'b0, 8'd0,   1'b0}, '{1'b1, 2'd1, PAGE0, NO_RES}},
        '{'{3'd4, 1'b0, 8'd255, 1'b0}, '{1'b1, 2'd0, NO_RES, NO_RES}},
        '{'{3'd7, 1'b0, 8'd200, 1'b0}, PREDICT},
        '{'{3'd0, 1'b1, 8'd0,   1'b0}, PREDICT},
        '{'{3'd5, 1'b1, 8'd0,   1'b0}, PREDICT},
        '{'{3'd2, 1'b0, 8'd0,   1'b1}, '{1'b1, 2'd1, SUMM1, NO_RES}},
        '{'{3'd3, 1'b1, 8'd255, 1'b1}, '{1'b1, 2'd2, PAGE0_M, SUMM1}},
        '{'{3'd6, 1'b0, 8'd128, 1'b0}, '{1'b1, 2'd1, PAGE0, NO_RES}},
        '{'{3'd1, 1'b0, 8'd1,   1'b0}, PREDICT},
        '{'{3'd4, 1'b0, 8'd255, 1'b0}, PREDICT},
        '{'{3'd4, 1'b0, 8'd64,  1'b0}, PREDICT},
        '{'{3'd1, 1'b0, 8'd1,   1'b0}, PREDICT},
        '{'{3'd2, 1'b1, 8'd0,   1'b0}, PREDICT},
        '{'{3'd1, 1'b0, 8'd0,   1'b1}, PREDICT},
        '{'{3'd0, 1'b0, 8'd0,   1'b1}, '{1'b1, 2'd2, PAGE0_M, SUMM1}},
        '{'{3'd7, 1'b1, 8'd255, 1'b0}, '{1'b1, 2'd1, PAGE0, NO_RES}}
    };

    localparam gtp_pkg::t_cfg LAYOUTS [12] = '{
        '{12'd448,  8'd20,  8'd24},
        '{12'd1,    8'd1,   8'd1},
        '{12'd4095, 8'd255, 8'd255},
        '{12'd0,    8'd0,   8'd0},
        '{12'd100,  8'd3,   8'd0},
        '{12'd255,  8'd1,   8'd255},
        '{12'd4095, 8'd1,   8'd1},
        '{12'd300,  8'd2,   8'd50},
        '{12'd12,   8'd255, 8'd8},
        '{12'd600,  8'd5,   8'd24},
        '{12'd2000, 8'd10,  8'd200},
        '{12'd40,   8'd4,   8'd16}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_push;
    logic                                o_full;
    gtp_pkg::t_item                      i_item;
    logic                                o_empty;
    logic                                i_pop;
    gtp_pkg::t_result                    o_result;
    logic                                i_cfg_we;
    logic [gtp_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [gtp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata;

    greedy_text_paginator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // layout registers as the predictor sees them
    logic [11:0]        lay_width;
    logic [7:0]         lay_lines;
    logic [7:0]         lay_adv;

    // text state
    int unsigned        line_fill;
    int unsigned        page_lines;
    logic [OFFS_W-1:0]  text_pos;
    int unsigned        pages_begun;
    bit                 line_open_pending;
    bit                 page_due;
    bit                 page_refused;

    gtp_pkg::t_result   pages_due [$];
    t_char_plan         char_plans [$];
    int                 err_count;
    int                 cycle_count;
    int                 push_idle_pct;
    int                 pop_idle_pct;
    int                 text_left;

    // handshake flags sampled mid-cycle, stable across the next rising edge
    logic               full_s;
    logic               empty_s;
    gtp_pkg::t_result   res_s;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_text();
        line_fill         = 0;
        page_lines        = 0;
        text_pos          = '0;
        pages_begun       = 0;
        line_open_pending = 1'b1;
        page_due          = 1'b1;
        page_refused      = 1'b0;
    endfunction

    function automatic void paginate_char(input gtp_pkg::t_item c, output int n,
                                          output gtp_pkg::t_result r0,
                                          output gtp_pkg::t_result r1);
        int unsigned      adv;
        int unsigned      lpp;
        bit               starts;
        gtp_pkg::t_result res [2];
        adv    = (c.advance_px == 8'd0) ? lay_adv : c.advance_px;
        starts = 1'b0;
        n      = 0;
        res[0] = '0;
        res[1] = '0;
        if (c.is_newline) begin
            if (line_open_pending) begin
                starts = 1'b1;
            end else begin
                line_open_pending = 1'b1;
                line_fill = 0;
            end
        end else begin
            if (!line_open_pending && line_fill + adv > lay_width) begin
                line_open_pending = 1'b1;
                line_fill = 0;
            end
            if (line_open_pending) begin
                starts = 1'b1;
                // a glyph wider than the whole line sits alone on it
                if (adv > lay_width) begin
                    line_fill = 0;
                end else begin
                    line_fill = adv;
                    line_open_pending = 1'b0;
                end
            end else begin
                line_fill += adv;
            end
        end
        if (starts) begin
            lpp = (lay_lines == 8'd0) ? 1 : lay_lines;
            if (page_due || page_lines >= lpp) begin
                if (pages_begun < gtp_pkg::MAX_PAGES_DEF) begin
                    res[0].page_number       = PAGE_W'(pages_begun);
                    res[0].page_start_offset = text_pos;
                    pages_begun++;
                    n = 1;
                end else begin
                    page_refused = 1'b1;
                end
                page_due   = 1'b0;
                page_lines = 1;
            end else begin
                page_lines++;
            end
        end
        text_pos = text_pos + OFFS_W'(c.byte_length);
        if (c.last_char) begin
            res[n].page_number   = (pages_begun > 4095) ? gtp_pkg::PAGE_FIELD_MAX
                                                        : PAGE_W'(pages_begun);
            res[n].is_summary    = 1'b1;
            res[n].limit_reached = page_refused;
            n++;
            clear_text();
        end
        if (n > 0) res[n-1].last_result = 1'b1;
        r0 = res[0];
        r1 = res[1];
    endfunction

    task automatic check_result(input gtp_pkg::t_result got,
                                input gtp_pkg::t_result want);
        if (got.page_number !== want.page_number) begin
            $display("%0t: page_number expected %0d, got %0d",
                     $time, want.page_number, got.page_number);
            err_count++;
        end
        if (got.page_start_offset !== want.page_start_offset) begin
            $display("%0t: page_start_offset expected %0d, got %0d",
                     $time, want.page_start_offset, got.page_start_offset);
            err_count++;
        end
        if (got.is_summary !== want.is_summary) begin
            $display("%0t: is_summary expected %b, got %b",
                     $time, want.is_summary, got.is_summary);
            err_count++;
        end
        if (got.limit_reached !== want.limit_reached) begin
            $display("%0t: limit_reached expected %b, got %b",
                     $time, want.limit_reached, got.limit_reached);
            err_count++;
        end
        if (got.last_result !== want.last_result) begin
            $display("%0t: last_result expected %b, got %b",
                     $time, want.last_result, got.last_result);
            err_count++;
        end
    endtask

    always @(negedge i_clk) begin
        full_s  = o_full;
        empty_s = o_empty;
        res_s   = o_result;
    end

    always @(posedge i_clk) begin
        i_pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    // accepted beats on both sides
    always @(posedge i_clk) begin
        t_char_plan       p;
        int               n;
        gtp_pkg::t_result r0;
        gtp_pkg::t_result r1;
        if (i_rst_n) begin
            if (i_push && !full_s) begin
                p = (char_plans.size() != 0) ? char_plans.pop_front() : PREDICT;
                paginate_char(i_item, n, r0, r1);
                if (p.typed) begin
                    n  = p.n;
                    r0 = p.r0;
                    r1 = p.r1;
                end
                if (n > 0) pages_due.push_back(r0);
                if (n > 1) pages_due.push_back(r1);
            end
            if (i_pop && !empty_s) begin
                if (pages_due.size() == 0) begin
                    $display("%0t: result expected none, got %h", $time, res_s);
                    err_count++;
                end else begin
                    check_result(res_s, pages_due.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_char(input gtp_pkg::t_item c, input t_char_plan p);
        char_plans.push_back(p);
        while ($urandom_range(99) < push_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= c;
        @(posedge i_clk);
        while (full_s) @(posedge i_clk);
    endtask

    task automatic settle();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pages_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [gtp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gtp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            gtp_pkg::CFG_LINE_WIDTH:  lay_width = data;
            gtp_pkg::CFG_PAGE_ROWS:   lay_lines = data[7:0];
            gtp_pkg::CFG_DEFAULT_ADV: lay_adv   = data[7:0];
            default: ;
        endcase
    endtask

    // upper data bits of the 8-bit registers carry junk
    task automatic load_layout(input gtp_pkg::t_cfg lay);
        put_reg(gtp_pkg::CFG_LINE_WIDTH, lay.line_width_px);
        put_reg(gtp_pkg::CFG_PAGE_ROWS, {4'($urandom), lay.page_rows});
        put_reg(gtp_pkg::CFG_DEFAULT_ADV, {4'($urandom), lay.default_advance_px});
        i_cfg_we <= 1'b0;
    endtask

    function automatic gtp_pkg::t_item rand_char(input bit last);
        gtp_pkg::t_item c;
        c.is_newline = ($urandom_range(99) < 12);
        case ($urandom_range(9))
            0, 1:    c.advance_px = 8'd0;
            2, 3:    c.advance_px = 8'($urandom_range(1, 16));
            default: c.advance_px = 8'($urandom);
        endcase
        c.byte_length = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 4))
                                                  : 3'($urandom_range(0, 7));
        c.last_char   = last;
        return c;
    endfunction

    // texts run on across segment boundaries
    task automatic run_segment(input int count);
        gtp_pkg::t_item c;
        repeat (count) begin
            if (text_left == 0)
                text_left = ($urandom_range(9) == 0) ? $urandom_range(41, 300)
                                                     : $urandom_range(1, 40);
            text_left--;
            c = rand_char(text_left == 0);
            send_char(c, PREDICT);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_push        = 1'b0;
        i_pop         = 1'b0;
        i_item        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        err_count     = 0;
        cycle_count   = 0;
        text_left     = 0;
        lay_width     = gtp_pkg::RST_LINE_WIDTH;
        lay_lines     = gtp_pkg::RST_PAGE_ROWS;
        lay_adv       = gtp_pkg::RST_DEFAULT_ADV;
        clear_text();
        push_idle_pct = 24;
        pop_idle_pct  = 75;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) send_char(DIR_ROWS[k].c, DIR_ROWS[k].p);

        for (int seg = 0; seg < 12; seg++) begin
            if (seg == 4) begin
                push_idle_pct = 75;
                pop_idle_pct  = 24;
            end
            if (seg == 8) begin
                push_idle_pct = 0;
                pop_idle_pct  = 0;
            end
            settle();
            if (seg == 0) put_reg(CFG_SPARE, 12'($urandom));
            load_layout(LAYOUTS[seg]);
            run_segment(SEG_ITEMS);
        end
        settle();

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/gtp_pkg.sv
hdl/gtp_front.sv
hdl/gtp_queue.sv
hdl/gtp_back.sv
hdl/greedy_text_paginator.sv
tb/greedy_text_paginator_tb.sv
